FILE: src/egd_pkg.sv
`timescale 1ns / 1ps

package egd_pkg;

    // Width of the code accumulator; a zero run that would reach CODE_BITS zeros is overlong
    localparam int CODE_BITS = 32;
    localparam int ZR_W      = $clog2(CODE_BITS);
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    localparam logic [STATUS_W-1:0] ST_VALUE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERLONG = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_BITS  = 4'b0010,
        S_TAIL  = 4'b0100,
        S_FLUSH = 4'b1000
    } egd_state_t;

endpackage

FILE: src/elias_gamma_decoder.sv
`timescale 1ns / 1ps
// Operation: an accepted byte is examined one bit per cycle, unless a bit is held because a
//   second result needs the busy output register; a result waits in the pending register first.
// Each byte passes through the bit-serial decode step, one end-of-byte step and one flush
//   step that also accepts the next byte.
// Reset: aresetn is synchronous, active low; it clears the decoder state, drops a held
//   result and any output transaction in flight.
module elias_gamma_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_final_byte,
    input  logic                          s_valid,
    output logic                          s_ready,
    output logic [egd_pkg::VALUE_W-1:0]   m_value,
    output logic [egd_pkg::STATUS_W-1:0]  m_status,
    output logic                          m_byte_done,
    output logic                          m_stream_end,
    output logic                          m_valid,
    input  logic                          m_ready
);
    import egd_pkg::*;

    localparam logic [ZR_W-1:0] ZR_MAX = ZR_W'(CODE_BITS - 1);

    // Control state
    egd_state_t           state_reg, state_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 final_reg, final_next;
    logic                 in_suffix_reg, in_suffix_next;
    logic [ZR_W-1:0]      zr_reg, zr_next;
    logic [ZR_W-1:0]      sl_reg, sl_next;
    logic [CODE_BITS-1:0] acc_reg, acc_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 m_valid_reg;

    // Payload
    logic [7:0]           sh_reg, sh_next;
    logic [VALUE_W-1:0]   pend_value_reg, pend_value_next;
    logic [STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic [VALUE_W-1:0]   m_value_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic                 m_byte_done_reg;
    logic                 m_stream_end_reg;

    // Bit-step datapath
    logic                         bit_b;
    logic [CODE_BITS-1:0]         acc_shift;
    logic [CODE_BITS-1:0]         acc_dec;
    logic [VALUE_W+CODE_BITS-1:0] acc_ext;
    logic                         gen;
    logic [VALUE_W-1:0]           gen_value;
    logic [STATUS_W-1:0]          gen_status;
    logic                         out_free;
    logic                         s_ready_c;
    logic                         push_en;
    logic                         push_done;
    logic                         push_end;
    logic                         extra;

    assign bit_b     = sh_reg[7];
    // The terminating one seeds acc with 1, so after z suffix bits acc = 2^z + suffix
    assign acc_shift = {acc_reg[CODE_BITS-2:0], bit_b};
    assign acc_dec   = acc_shift - CODE_BITS'(1);
    assign acc_ext   = {{VALUE_W{1'b0}}, acc_dec};
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        final_next       = final_reg;
        in_suffix_next   = in_suffix_reg;
        zr_next          = zr_reg;
        sl_next          = sl_reg;
        acc_next         = acc_reg;
        pend_valid_next  = pend_valid_reg;
        pend_value_next  = pend_value_reg;
        pend_status_next = pend_status_reg;
        sh_next          = sh_reg;
        gen              = 1'b0;
        gen_value        = '0;
        gen_status       = ST_VALUE;
        push_en          = 1'b0;
        push_done        = 1'b0;
        push_end         = 1'b0;
        s_ready_c        = 1'b0;
        extra            = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready_c = 1'b1;
            end

            S_BITS: begin
                // Decide whether this bit finishes a code
                if (!in_suffix_reg) begin
                    if (!bit_b) begin
                        if (zr_reg == ZR_MAX) begin
                            gen        = 1'b1;
                            gen_status = ST_OVERLONG;
                        end
                    end else if (zr_reg == '0) begin
                        gen = 1'b1;
                    end
                end else if (sl_reg == ZR_W'(1)) begin
                    gen       = 1'b1;
                    gen_value = acc_ext[VALUE_W-1:0];
                end

                // Hold the bit when a second result needs the busy output register
                if (!(gen && pend_valid_reg && !out_free)) begin
                    if (!in_suffix_reg) begin
                        if (!bit_b) begin
                            zr_next = (zr_reg == ZR_MAX) ? '0 : zr_reg + ZR_W'(1);
                        end else if (zr_reg != '0) begin
                            in_suffix_next = 1'b1;
                            sl_next        = zr_reg;
                            acc_next       = CODE_BITS'(1);
                        end
                    end else begin
                        acc_next = acc_shift;
                        sl_next  = sl_reg - ZR_W'(1);
                        if (sl_reg == ZR_W'(1)) begin
                            in_suffix_next = 1'b0;
                            zr_next        = '0;
                            sl_next        = '0;
                        end
                    end
                    if (gen) begin
                        push_en          = pend_valid_reg;
                        pend_valid_next  = 1'b1;
                        pend_value_next  = gen_value;
                        pend_status_next = gen_status;
                    end
                    sh_next  = {sh_reg[6:0], 1'b0};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'd7) begin
                        state_next = S_TAIL;
                    end
                end
            end

            S_TAIL: begin
                if (final_reg) begin
                    // Close the stream: cut-off code, dropped padding or an empty final byte
                    extra = in_suffix_reg || (zr_reg != '0) || !pend_valid_reg;
                    if (!(extra && pend_valid_reg && !out_free)) begin
                        if (extra) begin
                            push_en          = pend_valid_reg;
                            pend_valid_next  = 1'b1;
                            pend_value_next  = '0;
                            pend_status_next = in_suffix_reg ? ST_TRUNC : ST_END;
                        end
                        in_suffix_next = 1'b0;
                        zr_next        = '0;
                        sl_next        = '0;
                        acc_next       = '0;
                        state_next     = S_FLUSH;
                    end
                end else begin
                    state_next = S_FLUSH;
                end
            end

            S_FLUSH: begin
                // Release the byte's last result, marked byte_done
                if (pend_valid_reg) begin
                    if (out_free) begin
                        push_en         = 1'b1;
                        push_done       = 1'b1;
                        push_end        = final_reg;
                        pend_valid_next = 1'b0;
                        state_next      = S_IDLE;
                        s_ready_c       = 1'b1;
                    end
                end else begin
                    state_next = S_IDLE;
                    s_ready_c  = 1'b1;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (s_valid && s_ready_c) begin
            sh_next    = s_data_byte;
            final_next = s_final_byte;
            cnt_next   = '0;
            state_next = S_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            final_reg      <= 1'b0;
            in_suffix_reg  <= 1'b0;
            zr_reg         <= '0;
            sl_reg         <= '0;
            acc_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            final_reg      <= final_next;
            in_suffix_reg  <= in_suffix_next;
            zr_reg         <= zr_next;
            sl_reg         <= sl_next;
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
            if (push_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg          <= sh_next;
        pend_value_reg  <= pend_value_next;
        pend_status_reg <= pend_status_next;
        if (push_en) begin
            m_value_reg      <= pend_value_reg;
            m_status_reg     <= pend_status_reg;
            m_byte_done_reg  <= push_done;
            m_stream_end_reg <= push_end;
        end
    end

    assign s_ready      = s_ready_c;
    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_status     = m_status_reg;
    assign m_byte_done  = m_byte_done_reg;
    assign m_stream_end = m_stream_end_reg;

endmodule

FILE: src/egd_checker.sv
`timescale 1ns / 1ps

module egd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [egd_pkg::VALUE_W-1:0]   m_value,
    input logic [egd_pkg::STATUS_W-1:0]  m_status,
    input logic                          m_byte_done,
    input logic                          m_stream_end,
    input logic                          m_valid,
    input logic                          m_ready
);
    import egd_pkg::*;

    // End of stream always closes the byte too
    a_end_closes_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> m_byte_done)
        else $error("stream_end without byte_done");

    // Any non-value status carries a zero value
    a_status_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_VALUE) |-> (m_value == '0))
        else $error("nonzero value with error status");

    // End and truncation markers come only on the stream's last transaction
    a_end_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_status == ST_END) || (m_status == ST_TRUNC)) |-> m_stream_end)
        else $error("end status before stream end");

    // Stalled output holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_status)
            && $stable(m_byte_done) && $stable(m_stream_end))
        else $error("output changed while stalled");

endmodule

bind elias_gamma_decoder egd_checker u_egd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_value      (m_value),
    .m_status     (m_status),
    .m_byte_done  (m_byte_done),
    .m_stream_end (m_stream_end),
    .m_valid      (m_valid),
    .m_ready      (m_ready)
);
